// ===== hw/rtl/dfl_pkg.sv =====
`timescale 1ns / 1ps

package dfl_pkg;

  localparam int MAX_DIM    = 4096;
  localparam int DIM_W      = 13;
  localparam int COORD_W    = 12;
  localparam int D2_W       = 15;
  localparam int SQ_W       = 26;
  localparam int ROOT_BITS  = 24;
  localparam int BIT_IDX_W  = $clog2(ROOT_BITS);
  localparam int RES_W      = 42;
  localparam int TERM_W     = 58;
  localparam int TILT_W     = 48;
  localparam int GRAD_W     = 32;
  localparam int FOCAL_W    = 32;
  localparam int GAIN_W     = 24;
  localparam int SCALE_W    = 16;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_FOCAL_PIXELS = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_LENS_GAIN    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_LEFT_TILT    = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_RIGHT_TILT   = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] CFG_WAVE_SCALE   = 3'd6;

  typedef struct packed {
    logic [RES_W-1:0]         r;
    logic [ROOT_BITS-1:0]     e;
    logic signed [TILT_W-1:0] tilt;
    logic                     err;
  } root_t;

endpackage

// ===== hw/rtl/dfl_root_stage.sv =====
`timescale 1ns / 1ps

module dfl_root_stage import dfl_pkg::*; (
  input  logic                 clk,
  input  logic                 load,
  input  logic [BIT_IDX_W-1:0] bit_idx,
  input  logic [FOCAL_W-1:0]   focal,
  input  root_t                d,
  output root_t                q
);

  logic [TERM_W-1:0] one_b;
  logic [TERM_W-1:0] base;
  logic [TERM_W-1:0] term;
  logic              take;
  root_t             q_next;

  // trial bit b: (e+2^b)(2F+e+2^b) - e(2F+e) = 2^b(2F+2e+2^b)
  always_comb begin
    one_b  = TERM_W'(1) << bit_idx;
    base   = (TERM_W'(focal) << 1) + (TERM_W'(d.e) << 1) + one_b;
    term   = base << bit_idx;
    take   = term <= TERM_W'(d.r);
    q_next = d;
    if (take) begin
      q_next.r = d.r - RES_W'(term);
      q_next.e = d.e | ROOT_BITS'(one_b);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q <= q_next;
    end
  end

endmodule

// ===== hw/rtl/dual_fresnel_lens_phase_pixel_unit.sv =====
`timescale 1ns / 1ps
// the path from input request to result includes the 24-stage square root chain
// throughput: one pixel per cycle; each stage holds under back-pressure and bubbles close up
// reset: synchronous, clears all stage valid bits and loads the register defaults
// (width 1920, height 1152, focal 2782609, gain 279540, tilts 0, scale 4096)

module dual_fresnel_lens_phase_pixel_unit import dfl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [23:0]           s_axis_tdata,  // pixel_col [23:12], pixel_row [11:0]
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [7:0]            m_axis_tdata,  // phase_byte
  output logic                  m_axis_tuser   // coord_error
);

  localparam int NSTG     = 32;
  localparam int ROOT_FST = 3;

  logic [DIM_W-1:0]      image_width;
  logic [DIM_W-1:0]      image_height;
  logic [FOCAL_W-1:0]    focal_pixels;
  logic [GAIN_W-1:0]     lens_gain;
  logic [CFG_DATA_W-1:0] left_tilt;
  logic [CFG_DATA_W-1:0] right_tilt;
  logic [SCALE_W-1:0]    wave_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DIM_W'(1920);
      image_height <= DIM_W'(1152);
      focal_pixels <= FOCAL_W'(2782609);
      lens_gain    <= GAIN_W'(279540);
      left_tilt    <= '0;
      right_tilt   <= '0;
      wave_scale   <= SCALE_W'(4096);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_IMAGE_WIDTH:  image_width  <= cfg_data[DIM_W-1:0];
        CFG_IMAGE_HEIGHT: image_height <= cfg_data[DIM_W-1:0];
        CFG_FOCAL_PIXELS: focal_pixels <= cfg_data[FOCAL_W-1:0];
        CFG_LENS_GAIN:    lens_gain    <= cfg_data[GAIN_W-1:0];
        CFG_LEFT_TILT:    left_tilt    <= cfg_data;
        CFG_RIGHT_TILT:   right_tilt   <= cfg_data;
        CFG_WAVE_SCALE:   wave_scale   <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // stage handshake
  logic [NSTG-1:0] v;
  logic [NSTG:0]   go;

  always_comb begin
    go[NSTG] = m_axis_tready;
    for (int k = NSTG - 1; k >= 0; k--) begin
      go[k] = !v[k] || go[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (go[0]) begin
        v[0] <= s_axis_tvalid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (go[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  assign s_axis_tready = go[0];
  assign m_axis_tvalid = v[NSTG-1];

  // stage 0: bounds and half-pixel offsets
  logic [COORD_W-1:0]     in_row;
  logic [COORD_W-1:0]     in_col;
  logic [DIM_W-1:0]       w_eff;
  logic [DIM_W-1:0]       h_eff;
  logic [DIM_W-1:0]       half_w;
  logic signed [D2_W-1:0] cx2;
  logic                   in_err;
  logic                   in_left;

  always_comb begin
    in_row  = s_axis_tdata[11:0];
    in_col  = s_axis_tdata[23:12];
    w_eff   = (image_width > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : image_width;
    h_eff   = (image_height > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : image_height;
    half_w  = w_eff >> 1;
    in_err  = (DIM_W'(in_row) >= h_eff) || (DIM_W'(in_col) >= w_eff);
    in_left = DIM_W'(in_col) < half_w;
    if (in_left) begin
      cx2 = $signed(D2_W'(half_w)) - D2_W'(1);
    end else begin
      cx2 = $signed(D2_W'(half_w)) + $signed(D2_W'(w_eff)) - D2_W'(1);
    end
  end

  logic signed [D2_W-1:0] s0_dx2;
  logic signed [D2_W-1:0] s0_dy2;
  logic                   s0_left;
  logic                   s0_err;

  always_ff @(posedge clk) begin
    if (go[0]) begin
      s0_dx2  <= $signed(D2_W'({in_col, 1'b0})) - cx2;
      s0_dy2  <= $signed(D2_W'({in_row, 1'b0})) - ($signed(D2_W'(h_eff)) - D2_W'(1));
      s0_left <= in_left;
      s0_err  <= in_err;
    end
  end

  // stage 1: squares and tilt products
  logic [CFG_DATA_W-1:0]    tilt_sel;
  logic signed [GRAD_W-1:0] gx;
  logic signed [GRAD_W-1:0] gy;
  logic signed [2*D2_W-1:0] sqx_full;
  logic signed [2*D2_W-1:0] sqy_full;
  logic signed [TILT_W-1:0] tx_full;
  logic signed [TILT_W-1:0] ty_full;

  always_comb begin
    tilt_sel = s0_left ? left_tilt : right_tilt;
    gx       = $signed(tilt_sel[GRAD_W-1:0]);
    gy       = $signed(tilt_sel[2*GRAD_W-1:GRAD_W]);
    sqx_full = s0_dx2 * s0_dx2;
    sqy_full = s0_dy2 * s0_dy2;
    tx_full  = gx * s0_dx2;
    ty_full  = gy * s0_dy2;
  end

  logic [SQ_W-1:0]          s1_sqx;
  logic [SQ_W-1:0]          s1_sqy;
  logic signed [TILT_W-1:0] s1_tx;
  logic signed [TILT_W-1:0] s1_ty;
  logic                     s1_err;

  always_ff @(posedge clk) begin
    if (go[1]) begin
      s1_sqx <= sqx_full[SQ_W-1:0];
      s1_sqy <= sqy_full[SQ_W-1:0];
      s1_tx  <= tx_full;
      s1_ty  <= ty_full;
      s1_err <= s0_err;
    end
  end

  // stage 2: squared distance and tilt sum
  logic signed [TILT_W-1:0] tilt_sum;
  root_t                    rs [0:ROOT_BITS];

  assign tilt_sum = s1_tx + s1_ty;

  always_ff @(posedge clk) begin
    if (go[2]) begin
      rs[0].r    <= (RES_W'(s1_sqx) + RES_W'(s1_sqy)) << 14;
      rs[0].e    <= '0;
      rs[0].tilt <= tilt_sum >>> 9;
      rs[0].err  <= s1_err;
    end
  end

  // stages 3 to 26: one root bit per stage
  for (genvar j = 0; j < ROOT_BITS; j++) begin : g_root
    dfl_root_stage u_stage (
      .clk     (clk),
      .load    (go[ROOT_FST+j]),
      .bit_idx (BIT_IDX_W'(ROOT_BITS - 1 - j)),
      .focal   (focal_pixels),
      .d       (rs[j]),
      .q       (rs[j+1])
    );
  end

  // stage 27: lens product
  logic [GAIN_W+ROOT_BITS-1:0] s27_prod;
  logic signed [TILT_W-1:0]    s27_tilt;
  logic                        s27_err;

  always_ff @(posedge clk) begin
    if (go[27]) begin
      s27_prod <= lens_gain * rs[ROOT_BITS].e;
      s27_tilt <= rs[ROOT_BITS].tilt;
      s27_err  <= rs[ROOT_BITS].err;
    end
  end

  // stage 28: phase sum, lens term rounded toward minus infinity
  logic [GAIN_W+ROOT_BITS:0] prod_up;
  logic signed [TILT_W-1:0]  s28_p;
  logic                      s28_err;

  assign prod_up = (GAIN_W + ROOT_BITS + 1)'(s27_prod) + (GAIN_W + ROOT_BITS + 1)'(255);

  always_ff @(posedge clk) begin
    if (go[28]) begin
      s28_p   <= s27_tilt - $signed(TILT_W'(prod_up >> 8));
      s28_err <= s27_err;
    end
  end

  // stage 29: truncating remainder by one full wave
  logic [TILT_W-1:0]  mag;
  logic signed [24:0] rem;

  always_comb begin
    mag = s28_p[TILT_W-1] ? TILT_W'(-s28_p) : TILT_W'(s28_p);
    rem = s28_p[TILT_W-1] ? -$signed({1'b0, mag[23:0]}) : $signed({1'b0, mag[23:0]});
  end

  logic signed [24:0] s29_rem;
  logic               s29_err;

  always_ff @(posedge clk) begin
    if (go[29]) begin
      s29_rem <= rem;
      s29_err <= s28_err;
    end
  end

  // stage 30: scale
  logic signed [41:0] m_full;
  logic signed [41:0] s30_m;
  logic               s30_err;

  assign m_full = s29_rem * $signed({1'b0, wave_scale});

  always_ff @(posedge clk) begin
    if (go[30]) begin
      s30_m   <= m_full;
      s30_err <= s29_err;
    end
  end

  // stage 31: wrap negatives and truncate toward zero
  logic signed [42:0] m2;
  logic signed [42:0] qv;

  always_comb begin
    m2 = s30_m[41] ? (43'(s30_m) + (43'(1) <<< 36)) : 43'(s30_m);
    if (m2[42]) begin
      qv = (m2 + 43'((1 << 28) - 1)) >>> 28;
    end else begin
      qv = m2 >>> 28;
    end
  end

  always_ff @(posedge clk) begin
    if (go[31]) begin
      m_axis_tdata <= s30_err ? 8'd0 : qv[7:0];
      m_axis_tuser <= s30_err;
    end
  end

endmodule

// ===== tb/dual_fresnel_lens_phase_pixel_unit_test.sv =====
`timescale 1ns / 1ps

module dual_fresnel_lens_phase_pixel_unit_test;
  import dfl_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE = 3'd7;

  typedef struct {
    logic [7:0] phase_byte;
    logic       coord_error;
  } phase_res_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [23:0]           s_axis_tdata = '0;  // pixel_col [23:12], pixel_row [11:0]
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [7:0]            m_axis_tdata;       // phase_byte
  logic                  m_axis_tuser;       // coord_error

  dual_fresnel_lens_phase_pixel_unit dut (.*);

  // shadow copy of the registers
  logic [12:0] img_w, img_h;
  logic [31:0] focal;
  logic [23:0] gain;
  logic [63:0] tilt_l, tilt_r;
  logic [15:0] scale;

  phase_res_t phase_q[$];
  int  fails = 0;
  int  cycles = 0;
  bit  no_gap = 0;
  bit  no_stall = 0;
  int  hold_left = 0;
  int  stall_left = 0;

  initial forever #5 clk = ~clk;

  function automatic phase_res_t predict_phase(logic [11:0] row, logic [11:0] col);
    longint w, h, hw, cx2, dx2, dy2, gx, gy, lens, tilt, p, mag, rem, m;
    longint unsigned dsq, e, t, f;
    logic [63:0] treg;
    phase_res_t r;
    w = (img_w > MAX_DIM) ? MAX_DIM : longint'(img_w);
    h = (img_h > MAX_DIM) ? MAX_DIM : longint'(img_h);
    if (longint'(row) >= h || longint'(col) >= w) begin
      r.phase_byte = 8'd0;
      r.coord_error = 1'b1;
      return r;
    end
    hw = w / 2;
    if (longint'(col) < hw) begin
      cx2 = hw - 1;
      treg = tilt_l;
    end else begin
      cx2 = 2 * hw + (w - hw - 1);
      treg = tilt_r;
    end
    dx2 = 2 * longint'(col) - cx2;
    dy2 = 2 * longint'(row) - (h - 1);
    dsq = longint'(dx2 * dx2 + dy2 * dy2) << 14;
    f = focal;
    e = 0;
    for (int b = ROOT_BITS - 1; b >= 0; b--) begin
      t = e | (64'd1 << b);
      if (t * (2 * f + t) <= dsq) e = t;
    end
    lens = -longint'(longint'(gain) * e);
    gx = longint'(signed'(treg[31:0]));
    gy = longint'(signed'(treg[63:32]));
    tilt = gx * dx2 + gy * dy2;
    p = (lens >>> 8) + (tilt >>> 9);
    mag = (p < 0) ? -p : p;
    rem = mag & 64'hffffff;
    if (p < 0) rem = -rem;
    m = rem * longint'(scale);
    if (m < 0) m += longint'(256) << 28;
    m = m / (longint'(1) << 28);
    r.phase_byte = m[7:0];
    r.coord_error = 1'b0;
    return r;
  endfunction

  task automatic send_pixel(logic [11:0] row, logic [11:0] col);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {col, row};
    do @(posedge clk); while (!s_axis_tready);
    phase_q.push_back(predict_phase(row, col));
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (phase_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [63:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_IMAGE_WIDTH:  img_w = val[12:0];
      CFG_IMAGE_HEIGHT: img_h = val[12:0];
      CFG_FOCAL_PIXELS: focal = val[31:0];
      CFG_LENS_GAIN:    gain = val[23:0];
      CFG_LEFT_TILT:    tilt_l = val;
      CFG_RIGHT_TILT:   tilt_r = val;
      CFG_WAVE_SCALE:   scale = val[15:0];
      default: ;
    endcase
  endtask

  // receiver: random stalls, a long hold-off on request, checks each result
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (phase_q.size() == 0) begin
        $error("unexpected result phase_byte=%0d coord_error=%0d", m_axis_tdata, m_axis_tuser);
        fails++;
      end else begin
        phase_res_t x;
        x = phase_q.pop_front();
        if (m_axis_tdata !== x.phase_byte) begin
          $error("phase_byte expected %0d actual %0d", x.phase_byte, m_axis_tdata);
          fails++;
        end
        if (m_axis_tuser !== x.coord_error) begin
          $error("coord_error expected %0d actual %0d", x.coord_error, m_axis_tuser);
          fails++;
        end
      end
      stall_left = no_stall ? 0 : $urandom_range(0, 11);
    end else if (stall_left > 0) begin
      stall_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= (stall_left == 0);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 1500000) begin
      $display("dual_fresnel_lens_phase_pixel_unit regression: fail");
      $finish;
    end
  end

  task automatic test_default_corners;
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1151, 12'd1919);
    send_pixel(12'd575, 12'd479);
    send_pixel(12'd576, 12'd1440);
    send_pixel(12'd0, 12'd959);
    send_pixel(12'd0, 12'd960);
    send_pixel(12'd1152, 12'd0);
    send_pixel(12'd0, 12'd1920);
    send_pixel(12'd4095, 12'd4095);
  endtask

  task automatic test_sizes;
    write_reg(CFG_IMAGE_WIDTH, 64'd0);
    send_pixel(12'd0, 12'd0);
    write_reg(CFG_IMAGE_WIDTH, 64'd8191);
    write_reg(CFG_IMAGE_HEIGHT, 64'd8191);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd0, 12'd2048);
    write_reg(CFG_IMAGE_WIDTH, 64'd1);
    write_reg(CFG_IMAGE_HEIGHT, 64'd1);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd1, 12'd0);
    write_reg(CFG_IMAGE_HEIGHT, 64'd0);
    send_pixel(12'd0, 12'd0);
    write_reg(CFG_IMAGE_WIDTH, 64'd7);
    write_reg(CFG_IMAGE_HEIGHT, 64'd5);
    send_pixel(12'd2, 12'd2);
    send_pixel(12'd4, 12'd6);
  endtask

  task automatic test_gain_tilt_scale;
    write_reg(CFG_IMAGE_WIDTH, 64'd4096);
    write_reg(CFG_IMAGE_HEIGHT, 64'd4096);
    write_reg(CFG_FOCAL_PIXELS, 64'd0);
    write_reg(CFG_LENS_GAIN, 64'hffffff);
    write_reg(CFG_WAVE_SCALE, 64'hffff);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    write_reg(CFG_FOCAL_PIXELS, 64'hffffffff);
    write_reg(CFG_LEFT_TILT, 64'h80000000_7fffffff);
    write_reg(CFG_RIGHT_TILT, 64'h7fffffff_80000000);
    send_pixel(12'd0, 12'd0);
    send_pixel(12'd4095, 12'd4095);
    send_pixel(12'd2048, 12'd2047);
    write_reg(CFG_WAVE_SCALE, 64'd0);
    send_pixel(12'd100, 12'd3000);
    write_reg(CFG_SPARE, 64'hffffffff_ffffffff);
    send_pixel(12'd1, 12'd1);
  endtask

  task automatic random_config;
    int k;
    k = $urandom_range(0, 9);
    write_reg(CFG_IMAGE_WIDTH, k == 0 ? 64'($urandom_range(4097, 8191)) :
              k < 4 ? 64'd4096 : 64'($urandom_range(1, 4096)));
    k = $urandom_range(0, 9);
    write_reg(CFG_IMAGE_HEIGHT, k == 0 ? 64'($urandom_range(4097, 8191)) :
              k < 4 ? 64'd4096 : 64'($urandom_range(1, 4096)));
    k = $urandom_range(0, 3);
    write_reg(CFG_FOCAL_PIXELS, k == 0 ? 64'($urandom_range(0, 65535)) : 64'($urandom));
    write_reg(CFG_LENS_GAIN, 64'($urandom));
    write_reg(CFG_LEFT_TILT, {32'($urandom), 32'($urandom)});
    write_reg(CFG_RIGHT_TILT, {32'($urandom), 32'($urandom)});
    k = $urandom_range(0, 3);
    write_reg(CFG_WAVE_SCALE, k == 0 ? 64'd4096 : 64'($urandom));
  endtask

  task automatic random_pixels(int n);
    int wl, hl;
    wl = (img_w > MAX_DIM) ? MAX_DIM : img_w;
    hl = (img_h > MAX_DIM) ? MAX_DIM : img_h;
    repeat (n) begin
      if ($urandom_range(0, 9) < 8 && wl > 0 && hl > 0)
        send_pixel(12'($urandom_range(0, hl - 1)), 12'($urandom_range(0, wl - 1)));
      else
        send_pixel(12'($urandom), 12'($urandom));
    end
  endtask

  task automatic test_backpressure;
    drain();
    hold_left = 600;
    no_gap = 1;
    random_pixels(150);
    no_gap = 0;
  endtask

  task automatic test_random;
    for (int ph = 0; ph < 8; ph++) begin
      random_config();
      no_gap = (ph == 3);
      no_stall = (ph == 3);
      random_pixels(240);
    end
    no_gap = 0;
    no_stall = 0;
  endtask

  initial begin
    img_w = 13'd1920;
    img_h = 13'd1152;
    focal = 32'd2782609;
    gain = 24'd279540;
    tilt_l = '0;
    tilt_r = '0;
    scale = 16'd4096;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_default_corners();
    test_sizes();
    test_gain_tilt_scale();
    test_backpressure();
    test_random();
    drain();
    if (fails == 0) begin
      $display("dual_fresnel_lens_phase_pixel_unit regression: pass");
    end else begin
      $display("dual_fresnel_lens_phase_pixel_unit regression: fail");
    end
    $finish;
  end

endmodule
